// ===== rtl/core/fnv_mix_hash_unit_assert.svh =====
// assertion macros for the fnv mix hash unit checker
// expects signals named clk and rst in the scope where the macros are used
`ifndef FNV_MIX_HASH_UNIT_ASSERT_SVH
`define FNV_MIX_HASH_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define FMH_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define FMH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fmh_pkg.sv =====
// shared types, constants and microcode layout of the fnv mix hash unit
// no dependencies
`default_nettype none

package fmh_pkg;

  // hash constants
  localparam logic [63:0] OFFSET_BASIS    = 64'd1469598103934665603;
  localparam logic [63:0] GOLDEN_INC      = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A       = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B       = 64'h94d049bb133111eb;
  // fnv-64 prime is 2^40 + 0x1b3
  localparam int unsigned FNV_PRIME_SHIFT = 40;
  localparam logic [8:0]  FNV_PRIME_LOW   = 9'h1b3;
  localparam int unsigned BYTE_W          = 8;

  localparam int unsigned HASH_W = 64;
  localparam int unsigned FRAC_W = 53;
  localparam int unsigned HALF_W = HASH_W / 2;

  // microcode store
  localparam int unsigned UPC_W = 4;
  localparam int unsigned CNT_W = 3;
  localparam logic [CNT_W-1:0] WORD_CNT_INIT = CNT_W'(HASH_W / BYTE_W - 1);

  // item operations
  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_BYTE  = 2'd1,
    OP_WORD  = 2'd2,
    OP_MIX   = 2'd3
  } op_t;

  // datapath operations
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD_SEED,
    DP_FNV_STEP,
    DP_MIX_INIT,
    DP_XSH30,
    DP_MUL_LO,
    DP_MUL_HL,
    DP_MUL_LH,
    DP_XSH27,
    DP_FINISH
  } dp_op_t;

  typedef enum logic {
    K_A,
    K_B
  } ksel_t;

  // sequencing of a step
  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_LOOP,
    SEQ_END
  } seq_t;

  typedef struct packed {
    dp_op_t           op;
    ksel_t            ksel;
    seq_t             seq;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  // sequencer to datapath and output stage
  typedef struct packed {
    logic load;
    logic step;
    logic push;
  } seq_ctrl_t;

  // program entry points
  localparam logic [UPC_W-1:0] UA_BEGIN = 4'd0;
  localparam logic [UPC_W-1:0] UA_BYTE  = 4'd1;
  localparam logic [UPC_W-1:0] UA_WORD  = 4'd2;
  localparam logic [UPC_W-1:0] UA_MIX   = 4'd3;

  function automatic logic [UPC_W-1:0] entry_addr(input op_t op);
    logic [UPC_W-1:0] addr;
    unique case (op)
      OP_BEGIN: addr = UA_BEGIN;
      OP_BYTE:  addr = UA_BYTE;
      OP_WORD:  addr = UA_WORD;
      OP_MIX:   addr = UA_MIX;
      default:  addr = UA_BEGIN;
    endcase
    return addr;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fnv_mix_hash_unit.sv =====
// fnv mix hash unit top level: sequencer, microcode store, datapath, result register
// depends on fmh_pkg, fmh_ucode_rom, fmh_sequencer, fmh_datapath
`default_nettype none

// 64-bit hashing engine with one running hash, reset to the offset constant.
// Each item gives one result: the hash after the item and its top 53 bits.
// Items are handled one at a time, each as a run of microcode steps framed
// by an accept state and a result hand-off state: begin seeds the hash,
// byte absorb does an fnv-1a step, word absorb eight fnv-1a steps (one byte
// per cycle), mix the splitmix64 finalizer (the two 64-bit constant multiplies
// go through one shared 32x32 multiplier as three partial products each).
// A new item is taken as soon as the previous result is in the output
// register, even while that result is still stalled.
module fnv_mix_hash_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 operation,
  input  wire logic [fmh_pkg::HASH_W-1:0] data_value,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [fmh_pkg::HASH_W-1:0] hash_value,
  output logic      [fmh_pkg::FRAC_W-1:0] unit_fraction
);

  logic [fmh_pkg::UPC_W-1:0]  upc;
  fmh_pkg::uword_t            uword;
  fmh_pkg::seq_ctrl_t         ctrl;
  logic                       busy;
  logic                       out_free;
  logic [fmh_pkg::HASH_W-1:0] hash;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = busy;

  fmh_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .out_free  (out_free),
    .uword     (uword),
    .upc       (upc),
    .ctrl      (ctrl),
    .busy      (busy)
  );

  fmh_ucode_rom u_rom (
    .upc   (upc),
    .uword (uword)
  );

  fmh_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .uword      (uword),
    .data_value (data_value),
    .hash       (hash)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      hash_value <= hash;
    end
  end

  assign unit_fraction = hash_value[fmh_pkg::HASH_W-1:fmh_pkg::HASH_W-fmh_pkg::FRAC_W];

endmodule

`default_nettype wire

// ===== rtl/core/fmh_ucode_rom.sv =====
// microcode program store of the fnv mix hash unit
// depends on fmh_pkg
`default_nettype none

module fmh_ucode_rom (
  input  wire logic [fmh_pkg::UPC_W-1:0] upc,
  output fmh_pkg::uword_t                uword
);

  // one control word per step
  always_comb begin
    unique case (upc)
      // begin: seed the hash
      4'd0:    uword = '{fmh_pkg::DP_LOAD_SEED, fmh_pkg::K_A, fmh_pkg::SEQ_END, '0};
      // byte: single fnv-1a step
      4'd1:    uword = '{fmh_pkg::DP_FNV_STEP, fmh_pkg::K_A, fmh_pkg::SEQ_END, '0};
      // word: fnv-1a step repeated over all eight bytes
      4'd2:    uword = '{fmh_pkg::DP_FNV_STEP, fmh_pkg::K_A, fmh_pkg::SEQ_LOOP,
                         fmh_pkg::UA_WORD};
      // mix: splitmix64 finalizer
      4'd3:    uword = '{fmh_pkg::DP_MIX_INIT, fmh_pkg::K_A, fmh_pkg::SEQ_NEXT, '0};
      4'd4:    uword = '{fmh_pkg::DP_XSH30, fmh_pkg::K_A, fmh_pkg::SEQ_NEXT, '0};
      4'd5:    uword = '{fmh_pkg::DP_MUL_LO, fmh_pkg::K_A, fmh_pkg::SEQ_NEXT, '0};
      4'd6:    uword = '{fmh_pkg::DP_MUL_HL, fmh_pkg::K_A, fmh_pkg::SEQ_NEXT, '0};
      4'd7:    uword = '{fmh_pkg::DP_MUL_LH, fmh_pkg::K_A, fmh_pkg::SEQ_NEXT, '0};
      4'd8:    uword = '{fmh_pkg::DP_XSH27, fmh_pkg::K_A, fmh_pkg::SEQ_NEXT, '0};
      4'd9:    uword = '{fmh_pkg::DP_MUL_LO, fmh_pkg::K_B, fmh_pkg::SEQ_NEXT, '0};
      4'd10:   uword = '{fmh_pkg::DP_MUL_HL, fmh_pkg::K_B, fmh_pkg::SEQ_NEXT, '0};
      4'd11:   uword = '{fmh_pkg::DP_MUL_LH, fmh_pkg::K_B, fmh_pkg::SEQ_NEXT, '0};
      4'd12:   uword = '{fmh_pkg::DP_FINISH, fmh_pkg::K_A, fmh_pkg::SEQ_END, '0};
      default: uword = '{fmh_pkg::DP_NOP, fmh_pkg::K_A, fmh_pkg::SEQ_END, '0};
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/fmh_datapath.sv =====
// hash datapath: running hash, operand and work registers, shared 32x32 multiplier
// depends on fmh_pkg
`default_nettype none

module fmh_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire fmh_pkg::seq_ctrl_t         ctrl,
  input  wire fmh_pkg::uword_t            uword,
  input  wire logic [fmh_pkg::HASH_W-1:0] data_value,
  output logic      [fmh_pkg::HASH_W-1:0] hash
);

  localparam int unsigned HW = fmh_pkg::HASH_W;
  localparam int unsigned QW = fmh_pkg::HALF_W;

  logic [HW-1:0] opnd;
  logic [HW-1:0] work;
  logic [HW-1:0] prod_acc;

  logic [HW-1:0] fnv_x;
  logic [HW-1:0] fnv_res;
  logic [HW-1:0] kconst;
  logic [QW-1:0] mul_a;
  logic [QW-1:0] mul_b;
  logic [HW-1:0] mul_p;

  // fnv-1a step: xor byte, multiply by 2^40 + 0x1b3
  always_comb begin
    fnv_x   = hash ^ {{(HW - fmh_pkg::BYTE_W){1'b0}}, opnd[fmh_pkg::BYTE_W-1:0]};
    fnv_res = (fnv_x << fmh_pkg::FNV_PRIME_SHIFT)
            + (fnv_x * {{(HW - 9){1'b0}}, fmh_pkg::FNV_PRIME_LOW});
  end

  // shared multiplier operand selection
  always_comb begin
    kconst = (uword.ksel == fmh_pkg::K_B) ? fmh_pkg::MIX_MUL_B : fmh_pkg::MIX_MUL_A;
    mul_a  = (uword.op == fmh_pkg::DP_MUL_HL) ? work[HW-1:QW] : work[QW-1:0];
    mul_b  = (uword.op == fmh_pkg::DP_MUL_LH) ? kconst[HW-1:QW] : kconst[QW-1:0];
    mul_p  = {{QW{1'b0}}, mul_a} * {{QW{1'b0}}, mul_b};
  end

  // running hash
  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= fmh_pkg::OFFSET_BASIS;
    end else if (ctrl.step) begin
      unique case (uword.op)
        fmh_pkg::DP_LOAD_SEED: hash <= fmh_pkg::OFFSET_BASIS ^ opnd;
        fmh_pkg::DP_FNV_STEP:  hash <= fnv_res;
        fmh_pkg::DP_FINISH:    hash <= prod_acc ^ (prod_acc >> 31);
        default:               hash <= hash;
      endcase
    end
  end

  // operand, work and product registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      opnd <= data_value;
    end else if (ctrl.step) begin
      unique case (uword.op)
        fmh_pkg::DP_FNV_STEP: opnd <= opnd >> fmh_pkg::BYTE_W;
        fmh_pkg::DP_MIX_INIT: work <= (hash ^ opnd) + fmh_pkg::GOLDEN_INC;
        fmh_pkg::DP_XSH30:    work <= work ^ (work >> 30);
        fmh_pkg::DP_XSH27:    work <= prod_acc ^ (prod_acc >> 27);
        fmh_pkg::DP_MUL_LO:   prod_acc <= mul_p;
        fmh_pkg::DP_MUL_HL,
        fmh_pkg::DP_MUL_LH:   prod_acc[HW-1:QW] <= prod_acc[HW-1:QW] + mul_p[QW-1:0];
        default:              opnd <= opnd;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fmh_sequencer.sv =====
// microcode sequencer: step counter, loop counter and item handshake control
// depends on fmh_pkg
`default_nettype none

module fmh_sequencer (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic [1:0]                operation,
  input  wire logic                      out_free,
  input  wire fmh_pkg::uword_t           uword,
  output logic      [fmh_pkg::UPC_W-1:0] upc,
  output fmh_pkg::seq_ctrl_t             ctrl,
  output logic                           busy
);

  fmh_pkg::state_t           state;
  fmh_pkg::state_t           state_next;
  logic [fmh_pkg::UPC_W-1:0] upc_next;
  logic [fmh_pkg::CNT_W-1:0] cnt;
  logic [fmh_pkg::CNT_W-1:0] cnt_next;
  logic                      last_step;

  assign last_step = (uword.seq == fmh_pkg::SEQ_END)
                  || ((uword.seq == fmh_pkg::SEQ_LOOP) && (cnt == '0));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      fmh_pkg::ST_IDLE: if (in_valid) state_next = fmh_pkg::ST_RUN;
      fmh_pkg::ST_RUN:  if (last_step) state_next = fmh_pkg::ST_DONE;
      fmh_pkg::ST_DONE: if (out_free) state_next = fmh_pkg::ST_IDLE;
      default:          state_next = fmh_pkg::ST_IDLE;
    endcase
  end

  // step counter and loop counter
  always_comb begin
    upc_next = upc;
    cnt_next = cnt;
    if (state == fmh_pkg::ST_IDLE) begin
      upc_next = fmh_pkg::entry_addr(fmh_pkg::op_t'(operation));
      cnt_next = fmh_pkg::WORD_CNT_INIT;
    end else if (state == fmh_pkg::ST_RUN) begin
      unique case (uword.seq)
        fmh_pkg::SEQ_NEXT: upc_next = upc + 1'b1;
        fmh_pkg::SEQ_LOOP: begin
          if (cnt != '0) begin
            upc_next = uword.target;
            cnt_next = cnt - 1'b1;
          end
        end
        default: upc_next = upc;
      endcase
    end
  end

  // control outputs
  always_comb begin
    busy      = (state != fmh_pkg::ST_IDLE);
    ctrl.load = (state == fmh_pkg::ST_IDLE) && in_valid;
    ctrl.step = (state == fmh_pkg::ST_RUN);
    ctrl.push = (state == fmh_pkg::ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmh_pkg::ST_IDLE;
      upc   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      upc   <= upc_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/fmh_checker.sv =====
// port-level checker for the fnv mix hash unit, bound to the top level
// depends on fmh_pkg and fnv_mix_hash_unit_assert.svh
`default_nettype none

`include "fnv_mix_hash_unit_assert.svh"

module fmh_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic [1:0]                 operation,
  input wire logic [fmh_pkg::HASH_W-1:0] data_value,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [fmh_pkg::HASH_W-1:0] hash_value
);

  logic in_acc;
  logic seed_fast;

  assign in_acc    = in_valid && !in_stall;
  assign seed_fast = in_acc && (operation == fmh_pkg::OP_BEGIN) && (!out_valid || !out_stall);

  // an accepted item keeps the unit busy in the next cycle
  `FMH_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "no busy after accept")

  // the unit only becomes busy by accepting an item
  `FMH_ASSERT_SAME(a_busy_cause, $rose(in_stall), $past(in_acc), "busy without accept")

  // a begin with a free output slot shows the seeded hash after the run and done states
  `FMH_ASSERT_SAME(a_seed_result, seed_fast,
    ##3 (out_valid && (hash_value == (fmh_pkg::OFFSET_BASIS ^ $past(data_value, 3)))),
    "wrong or late seed result")

  // a stalled result holds
  `FMH_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(hash_value), "stalled result changed")

endmodule

bind fnv_mix_hash_unit fmh_checker u_fmh_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .operation  (operation),
  .data_value (data_value),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .hash_value (hash_value)
);

`default_nettype wire

// ===== tb/sv/fnv_mix_hash_unit_tb.sv =====
// self-checking testbench for the fnv mix hash unit: directed items, long output hold, random
// sequences under three idle mixes; depends on fmh_pkg and fnv_mix_hash_unit
`timescale 1ns / 100ps

module fnv_mix_hash_unit_tb;

  localparam logic [63:0] FNV_PRIME   = 64'd1099511628211;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          MAX_REPORTS = 60;
  localparam int          PHASE_ITEMS = 310;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic [1:0]  operation  = fmh_pkg::OP_BEGIN;
  logic [63:0] data_value = 64'd0;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [63:0] hash_value;
  logic [52:0] unit_fraction;

  // predictor state and expected hashes in arrival order
  logic [63:0] model_hash = fmh_pkg::OFFSET_BASIS;
  logic [63:0] hash_expect_q[$];

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int mismatches   = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int input_stalls = 0;
  int op_count[4]  = '{0, 0, 0, 0};

  fnv_mix_hash_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .data_value   (data_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hash_value   (hash_value),
    .unit_fraction(unit_fraction)
  );

  always #10 clk = ~clk;

  // one fnv-1a step: xor in a byte, multiply by the prime mod 2^64
  function automatic logic [63:0] fnv_byte_step(input logic [63:0] h, input logic [7:0] b);
    return (h ^ {56'd0, b}) * FNV_PRIME;
  endfunction

  // splitmix64 finalizer
  function automatic logic [63:0] splitmix_finalize(input logic [63:0] x);
    logic [63:0] v;
    v = x + fmh_pkg::GOLDEN_INC;
    v = (v ^ (v >> 30)) * fmh_pkg::MIX_MUL_A;
    v = (v ^ (v >> 27)) * fmh_pkg::MIX_MUL_B;
    return v ^ (v >> 31);
  endfunction

  // running hash after one item
  function automatic logic [63:0] next_running_hash(input fmh_pkg::op_t op,
                                                    input logic [63:0] val,
                                                    input logic [63:0] h);
    logic [63:0] acc;
    acc = h;
    case (op)
      fmh_pkg::OP_BEGIN: acc = fmh_pkg::OFFSET_BASIS ^ val;
      fmh_pkg::OP_BYTE:  acc = fnv_byte_step(acc, val[7:0]);
      fmh_pkg::OP_WORD: begin
        for (int k = 0; k < 8; k++) acc = fnv_byte_step(acc, val[8*k +: 8]);
      end
      fmh_pkg::OP_MIX:   acc = splitmix_finalize(acc ^ val);
    endcase
    return acc;
  endfunction

  // random 64-bit value with a bias toward edge patterns
  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    case ($urandom_range(7))
      0:       w = 64'd0;
      1:       w = '1;
      2:       w = 64'd1 << $urandom_range(63);
      3:       w = {8{8'($urandom)}};
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
  endtask

  // send one item; starts and ends at a falling edge, valid stays high after acceptance
  task automatic send_item(input fmh_pkg::op_t op, input logic [63:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    operation  = op;
    data_value = val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_hash = next_running_hash(op, val, model_hash);
    hash_expect_q.insert(hash_expect_q.size(), model_hash);
    op_count[op]++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (hash_expect_q.size() != 0) @(negedge clk);
  endtask

  // items before any begin work on the reset hash
  task automatic test_reset_state();
    send_item(fmh_pkg::OP_BYTE, 64'hffff_ffff_ffff_ffa5);
    send_item(fmh_pkg::OP_WORD, '1);
    send_item(fmh_pkg::OP_MIX, 64'd0);
    wait_drain();
  endtask

  // field extremes and every operation
  task automatic test_field_extremes();
    send_item(fmh_pkg::OP_BEGIN, 64'd0);
    send_item(fmh_pkg::OP_BYTE, 64'd0);
    send_item(fmh_pkg::OP_BYTE, 64'hff);
    send_item(fmh_pkg::OP_BYTE, 64'hffff_ffff_ffff_ff00);
    send_item(fmh_pkg::OP_WORD, 64'd0);
    send_item(fmh_pkg::OP_WORD, '1);
    send_item(fmh_pkg::OP_MIX, '1);
    send_item(fmh_pkg::OP_BEGIN, '1);
    send_item(fmh_pkg::OP_MIX, 64'd0);
    send_item(fmh_pkg::OP_WORD, 64'h0123_4567_89ab_cdef);
    send_item(fmh_pkg::OP_BEGIN, 64'h8000_0000_0000_0000);
    send_item(fmh_pkg::OP_MIX, 64'd1);
    send_item(fmh_pkg::OP_BEGIN, {$urandom, $urandom});
    send_item(fmh_pkg::OP_WORD, {$urandom, $urandom});
    send_item(fmh_pkg::OP_MIX, {$urandom, $urandom});
    wait_drain();
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_output_hold();
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    hold_request = 1'b1;
    send_item(fmh_pkg::OP_BEGIN, rand_word());
    repeat (10) send_item($urandom_range(1) ? fmh_pkg::OP_WORD : fmh_pkg::OP_BYTE, rand_word());
    send_item(fmh_pkg::OP_MIX, rand_word());
    wait_drain();
  endtask

  // mostly begin / absorb / mix sequences, some stray items
  task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n_items);
    int sent;
    int len;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_item(fmh_pkg::op_t'($urandom_range(3)), rand_word());
        sent++;
      end else begin
        send_item(fmh_pkg::OP_BEGIN, rand_word());
        len = $urandom_range(1, 8);
        repeat (len)
          send_item($urandom_range(1) ? fmh_pkg::OP_BYTE : fmh_pkg::OP_WORD, rand_word());
        sent += len + 1;
        if ($urandom_range(3) != 0) begin
          send_item(fmh_pkg::OP_MIX, rand_word());
          sent++;
        end
      end
    end
    wait_drain();
  endtask

  // receiver stall, with a long hold on request
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < rx_idle_pct);
    end
  end

  // compare each result with the oldest expected hash
  always @(posedge clk) begin : check_results
    logic [63:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (hash_expect_q.size() == 0) begin
        report_mismatch("result with no item pending", hash_value, 64'd0);
      end else begin
        want = hash_expect_q.pop_front();
        results_seen++;
        if (hash_value !== want) report_mismatch("hash_value", hash_value, want);
        if (unit_fraction !== want[63:11])
          report_mismatch("unit_fraction", {11'd0, unit_fraction}, {11'd0, want[63:11]});
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (in_valid && in_stall) input_stalls++;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("fnv_mix_hash_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_reset_state();
    test_field_extremes();
    test_output_hold();
    test_random_phase(15, 72, PHASE_ITEMS);
    test_random_phase(72, 15, PHASE_ITEMS);
    test_random_phase(0, 0, PHASE_ITEMS);
    repeat (30) @(negedge clk);
    $display("items: %0d begin, %0d byte, %0d word, %0d mix; %0d results checked",
             op_count[fmh_pkg::OP_BEGIN], op_count[fmh_pkg::OP_BYTE],
             op_count[fmh_pkg::OP_WORD], op_count[fmh_pkg::OP_MIX], results_seen);
    $display("three idle mixes plus a %0d-cycle output hold; input stalled %0d cycles",
             HOLD_CYCLES, input_stalls);
    if (mismatches == 0) begin
      $display("fnv_mix_hash_unit: match");
    end else begin
      $display("fnv_mix_hash_unit: mismatch");
    end
    $finish;
  end

endmodule
